>>> src/bsmap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmap_pkg: shared types and constants of the bank switch mapper
// Function codes, write decode addresses, reset values and bus widths.
// ----------------------------------------------------------------------------
package bsmap_pkg;

    // Operation carried by one input transaction
    typedef enum logic [1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_CPU_XLATE = 2'd2,
        FUNC_CHR_XLATE = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic {
        CFG_PRG_MASK = 1'b0,
        CFG_CHR_MASK = 1'b1
    } t_cfg_idx;

    // Bus widths
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 1;
    localparam int MAP_ADDR_W = 21;
    localparam int BANK_W     = 8;
    localparam int CNT_W      = 16;

    // CPU write decode
    localparam logic [15:0] WR_DECODE_MASK = 16'hE00F;
    localparam logic [15:0] SEL_CHR_FIRST  = 16'h8000;
    localparam logic [15:0] SEL_CHR_LAST   = 16'h8007;
    localparam logic [15:0] SEL_PRG_FIRST  = 16'h8008;
    localparam logic [15:0] SEL_PRG_LAST   = 16'h800B;
    localparam logic [15:0] SEL_CNT_CLEAR  = 16'h800D;
    localparam logic [15:0] SEL_IRQ_ACK    = 16'h800F;

    // Counter bit that raises the interrupt
    localparam int IRQ_COUNT_BIT = 12;

    // Reset values
    localparam logic [BANK_W-1:0] PRG_BANK_RESET_BASE = 8'hFC;
    localparam logic [BANK_W-1:0] BANK_MASK_RESET     = 8'hFF;

endpackage : bsmap_pkg

>>> src/bank_switch_mapper_with_cycle_irq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_cycle_irq: cartridge mapper with cycle interrupt
// Decodes CPU writes into bank registers, counts tick transactions toward an
// interrupt and translates CPU and pattern addresses through the banks.
// ----------------------------------------------------------------------------
// Channel   | Direction | Fields (lowest bit first)
// s_axis    | in        | tdata: address[15:0], value[23:16]; tuser: func[1:0]
// m_axis    | out       | tdata: irq_line[0], mapped_address[21:1], zero[23:22];
//           |           | tuser: mapped_valid[0]
// cfg       | in        | write enable, index (0 prg mask, 1 chr mask), 8-bit data
//
// One transaction per cycle while ready; the result shows in the next cycle.
// Bank, counter and interrupt state update in the same edge as acceptance,
// so the next transaction sees it at once. The output register decouples the
// sides: s_axis_tready is high whenever that register is empty or drains.
// Reset is synchronous and loads all bank registers, masks and the counter.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_cycle_irq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // address[15:0], value[23:16]
    input  wire logic [bsmap_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [bsmap_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // irq_line[0], mapped_address[21:1], zero[23:22]
    output logic [bsmap_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // mapped_valid[0]
    output logic [bsmap_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    // Configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [bsmap_pkg::BANK_W-1:0]  i_cfg_data
);

    // State
    logic [bsmap_pkg::BANK_W-1:0]     r_prg_bank [4];
    logic [bsmap_pkg::BANK_W-1:0]     r_chr_bank [8];
    logic [bsmap_pkg::BANK_W-1:0]     r_prg_mask;
    logic [bsmap_pkg::BANK_W-1:0]     r_chr_mask;
    logic [bsmap_pkg::CNT_W-1:0]      r_cnt;
    logic                             r_irq;

    // Output register
    logic                             r_out_valid;
    logic                             r_out_irq;
    logic [bsmap_pkg::MAP_ADDR_W-1:0] r_out_addr;
    logic                             r_out_mvalid;

    // Next values and decode
    logic                             accept;
    bsmap_pkg::t_func                 func;
    logic [15:0]                      addr;
    logic [bsmap_pkg::BANK_W-1:0]     wdata;
    logic [15:0]                      sel;
    logic                             wr_chr;
    logic                             wr_prg;
    logic [bsmap_pkg::CNT_W-1:0]      n_cnt;
    logic                             n_irq;
    logic [bsmap_pkg::BANK_W-1:0]     prg_bank;
    logic [bsmap_pkg::BANK_W-1:0]     chr_bank;
    logic [bsmap_pkg::MAP_ADDR_W-1:0] n_out_addr;
    logic                             n_out_mvalid;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    assign func  = bsmap_pkg::t_func'(s_axis_tuser);
    assign addr  = s_axis_tdata[15:0];
    assign wdata = s_axis_tdata[23:16];
    assign sel   = addr & bsmap_pkg::WR_DECODE_MASK;

    // Bank lookups for both translate kinds
    assign prg_bank = r_prg_bank[addr[14:13]] & r_prg_mask;
    assign chr_bank = r_chr_bank[addr[12:10]] & r_chr_mask;

    // Decode the transaction: state updates and result
    always_comb begin
        wr_chr       = 1'b0;
        wr_prg       = 1'b0;
        n_cnt        = r_cnt;
        n_irq        = r_irq;
        n_out_addr   = '0;
        n_out_mvalid = 1'b0;
        case (func)
            bsmap_pkg::FUNC_WRITE: begin
                case (sel) inside
                    [bsmap_pkg::SEL_CHR_FIRST:bsmap_pkg::SEL_CHR_LAST]: wr_chr = 1'b1;
                    [bsmap_pkg::SEL_PRG_FIRST:bsmap_pkg::SEL_PRG_LAST]: wr_prg = 1'b1;
                    bsmap_pkg::SEL_CNT_CLEAR:                             n_cnt  = '0;
                    bsmap_pkg::SEL_IRQ_ACK:                               n_irq  = 1'b0;
                    default: ;
                endcase
            end
            bsmap_pkg::FUNC_TICK: begin
                n_cnt = r_cnt + 1'b1;
                if (n_cnt[bsmap_pkg::IRQ_COUNT_BIT]) begin
                    n_irq = 1'b1;
                end
            end
            bsmap_pkg::FUNC_CPU_XLATE: begin
                // 8 KB windows from 0x8000 up
                if (addr[15]) begin
                    n_out_addr   = {prg_bank, addr[12:0]};
                    n_out_mvalid = 1'b1;
                end
            end
            bsmap_pkg::FUNC_CHR_XLATE: begin
                // 1 KB windows below 0x2000
                if (addr[15:13] == 3'd0) begin
                    n_out_addr   = {3'd0, chr_bank, addr[9:0]};
                    n_out_mvalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Update mapper state on each accepted transaction and on config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_prg_bank[i] <= bsmap_pkg::PRG_BANK_RESET_BASE + 8'(i);
            end
            for (int i = 0; i < 8; i++) begin
                r_chr_bank[i] <= 8'(i);
            end
            r_prg_mask <= bsmap_pkg::BANK_MASK_RESET;
            r_chr_mask <= bsmap_pkg::BANK_MASK_RESET;
            r_cnt      <= '0;
            r_irq      <= 1'b0;
        end else begin
            if (accept) begin
                if (wr_chr) begin
                    r_chr_bank[sel[2:0]] <= wdata;
                end
                if (wr_prg) begin
                    r_prg_bank[sel[1:0]] <= wdata;
                end
                r_cnt <= n_cnt;
                r_irq <= n_irq;
            end
            if (i_cfg_we) begin
                case (bsmap_pkg::t_cfg_idx'(i_cfg_idx))
                    bsmap_pkg::CFG_PRG_MASK: r_prg_mask <= i_cfg_data;
                    bsmap_pkg::CFG_CHR_MASK: r_chr_mask <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_irq    <= n_irq;
            r_out_addr   <= n_out_addr;
            r_out_mvalid <= n_out_mvalid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_addr, r_out_irq};
    assign m_axis_tuser  = r_out_mvalid;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // A tick advances the counter by exactly one
    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && func == bsmap_pkg::FUNC_TICK |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("tick did not advance the cycle counter");

    // A tick that reaches the interrupt bit reports the interrupt
    a_tick_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && func == bsmap_pkg::FUNC_TICK && n_cnt[bsmap_pkg::IRQ_COUNT_BIT]
        |=> m_axis_tvalid && m_axis_tdata[0])
        else $error("interrupt missing after counter reached its bit");

    // Writes and ticks never produce a mapped address
    a_no_map_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (func == bsmap_pkg::FUNC_WRITE || func == bsmap_pkg::FUNC_TICK)
        |=> !m_axis_tuser[0] && m_axis_tdata[21:1] == '0)
        else $error("write or tick produced a mapped address");

endmodule : bank_switch_mapper_with_cycle_irq
`default_nettype wire

>>> tb/bank_switch_mapper_with_cycle_irq_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_cycle_irq_tb: self-checking bench for the mapper
// Drives write, tick and translate transactions with random gaps and output
// stalls, predicts every result from an internal copy of the bank, mask,
// counter and interrupt state, and compares the irq, address and valid fields in order.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_cycle_irq_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RAND_PER_PHASE = 278;

    // One result as the mapper reports it
    typedef struct {
        logic                             irq_line;
        logic [bsmap_pkg::MAP_ADDR_W-1:0] mapped_address;
        logic                             mapped_valid;
    } t_map_out;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bsmap_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [bsmap_pkg::S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bsmap_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [bsmap_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                            i_cfg_we      = 1'b0;
    logic                            i_cfg_idx     = 1'b0;
    logic [bsmap_pkg::BANK_W-1:0]    i_cfg_data    = '0;

    // Mirror of the mapper state
    logic [bsmap_pkg::BANK_W-1:0] prg_banks [4];
    logic [bsmap_pkg::BANK_W-1:0] chr_banks [8];
    logic [bsmap_pkg::CNT_W-1:0]  cycle_count;
    logic                         irq_pend;
    logic [bsmap_pkg::BANK_W-1:0] prg_mask;
    logic [bsmap_pkg::BANK_W-1:0] chr_mask;

    t_map_out map_out_q[$];
    int       mismatches   = 0;
    int       items_sent   = 0;
    int       results_seen = 0;
    int       mask_settings = 0;
    int       irq_rises    = 0;
    int       idle_cycles  = 0;
    bit       src_idle_en  = 1'b1;
    bit       snk_idle_en  = 1'b1;

    bank_switch_mapper_with_cycle_irq dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // address[15:0], value[23:16]
        .s_axis_tuser  (s_axis_tuser),   // func[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // irq_line[0], mapped_address[21:1], zero[23:22]
        .m_axis_tuser  (m_axis_tuser),   // mapped_valid[0]
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Apply one transaction to the mirrored state and return its result
    function automatic t_map_out apply_bus_item(bsmap_pkg::t_func f, logic [15:0] addr,
                                                logic [7:0] val);
        t_map_out                     res;
        logic [15:0]                  sel;
        logic [bsmap_pkg::BANK_W-1:0] bank;
        logic                         was_pending;
        res = '{irq_line: 1'b0, mapped_address: '0, mapped_valid: 1'b0};
        was_pending = irq_pend;
        case (f)
            bsmap_pkg::FUNC_WRITE: begin
                sel = addr & bsmap_pkg::WR_DECODE_MASK;
                if (sel >= bsmap_pkg::SEL_CHR_FIRST && sel <= bsmap_pkg::SEL_CHR_LAST) begin
                    chr_banks[sel[2:0]] = val;
                end else if (sel >= bsmap_pkg::SEL_PRG_FIRST &&
                             sel <= bsmap_pkg::SEL_PRG_LAST) begin
                    prg_banks[sel[1:0]] = val;
                end else if (sel == bsmap_pkg::SEL_CNT_CLEAR) begin
                    cycle_count = '0;
                end else if (sel == bsmap_pkg::SEL_IRQ_ACK) begin
                    irq_pend = 1'b0;
                end
            end
            bsmap_pkg::FUNC_TICK: begin
                cycle_count = cycle_count + 1'b1;
                if (cycle_count[bsmap_pkg::IRQ_COUNT_BIT]) begin
                    irq_pend = 1'b1;
                end
            end
            bsmap_pkg::FUNC_CPU_XLATE: begin
                if (addr[15]) begin
                    bank = prg_banks[addr[14:13]] & prg_mask;
                    res.mapped_address = {bank, addr[12:0]};
                    res.mapped_valid   = 1'b1;
                end
            end
            default: begin
                if (addr < 16'h2000) begin
                    bank = chr_banks[addr[12:10]] & chr_mask;
                    res.mapped_address = {3'b000, bank, addr[9:0]};
                    res.mapped_valid   = 1'b1;
                end
            end
        endcase
        if (irq_pend && !was_pending) begin
            irq_rises++;
        end
        res.irq_line = irq_pend;
        return res;
    endfunction

    // Hold reset low, release it and load the mirror with reset values
    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            prg_banks[i] = bsmap_pkg::PRG_BANK_RESET_BASE + 8'(i);
        end
        for (int i = 0; i < 8; i++) begin
            chr_banks[i] = 8'(i);
        end
        cycle_count = '0;
        irq_pend    = 1'b0;
        prg_mask    = bsmap_pkg::BANK_MASK_RESET;
        chr_mask    = bsmap_pkg::BANK_MASK_RESET;
    endtask

    // Write one mask register; only called while the mapper is idle
    task automatic cfg_write(bsmap_pkg::t_cfg_idx idx, logic [bsmap_pkg::BANK_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bsmap_pkg::CFG_PRG_MASK: prg_mask = data;
            default:                 chr_mask = data;
        endcase
        @(posedge i_clk);
    endtask

    // Send one transaction after a random gap and record its expected result
    task automatic send_item(bsmap_pkg::t_func f, logic [15:0] addr, logic [7:0] val);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, addr};
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        map_out_q.push_back(apply_bus_item(f, addr, val));
        items_sent++;
    endtask

    // Drop valid, let every result drain, then allow for the output stage
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (map_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Back-to-back ticks with no idling on either side
    task automatic tick_run(int n);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        repeat (n) send_item(bsmap_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    task automatic test_reset_banks();
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'h0000, 8'h00);
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'h7FFF, 8'hFF);
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'h8000, 8'h00);
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'hBFFF, 8'h00);
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'hC123, 8'h00);
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'hFFFF, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'h0000, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'h07FF, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'h1FFF, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'h2000, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'hFFFF, 8'h00);
    endtask

    task automatic test_bank_writes();
        send_item(bsmap_pkg::FUNC_WRITE, 16'h8000, 8'hFF);
        // Middle address bits are outside the decode mask
        send_item(bsmap_pkg::FUNC_WRITE, 16'h9FF7, 8'h00);
        send_item(bsmap_pkg::FUNC_WRITE, 16'h8008, 8'h80);
        send_item(bsmap_pkg::FUNC_WRITE, 16'h9FFB, 8'h7F);
        // Unmatched selects leave everything alone
        send_item(bsmap_pkg::FUNC_WRITE, 16'h800C, 8'h55);
        send_item(bsmap_pkg::FUNC_WRITE, 16'h800E, 8'hAA);
        send_item(bsmap_pkg::FUNC_WRITE, 16'hA000, 8'h12);
        send_item(bsmap_pkg::FUNC_WRITE, 16'h0008, 8'h34);
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'h8000, 8'h00);
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'hFFFF, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'h0000, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'h1FFF, 8'h00);
    endtask

    task automatic test_zero_masks();
        wait_idle();
        cfg_write(bsmap_pkg::CFG_PRG_MASK, 8'h00);
        cfg_write(bsmap_pkg::CFG_CHR_MASK, 8'h00);
        mask_settings++;
        send_item(bsmap_pkg::FUNC_CPU_XLATE, 16'hFFFF, 8'h00);
        send_item(bsmap_pkg::FUNC_CHR_XLATE, 16'h03FF, 8'h00);
        wait_idle();
        cfg_write(bsmap_pkg::CFG_PRG_MASK, 8'hFF);
        cfg_write(bsmap_pkg::CFG_CHR_MASK, 8'hFF);
        mask_settings++;
    endtask

    task automatic test_cycle_irq();
        send_item(bsmap_pkg::FUNC_WRITE, bsmap_pkg::SEL_CNT_CLEAR, 8'h00);
        send_item(bsmap_pkg::FUNC_WRITE, bsmap_pkg::SEL_IRQ_ACK, 8'h00);
        // Count a short back-to-back run of ticks
        tick_run(24);
        // Clearing the counter between runs restarts the count
        send_item(bsmap_pkg::FUNC_WRITE, bsmap_pkg::SEL_CNT_CLEAR, 8'h00);
        send_item(bsmap_pkg::FUNC_TICK, 16'h0000, 8'h00);
        // Acknowledge with nothing pending leaves the line low
        send_item(bsmap_pkg::FUNC_WRITE, bsmap_pkg::SEL_IRQ_ACK, 8'h00);
        tick_run(8);
        send_item(bsmap_pkg::FUNC_TICK, 16'hFFFF, 8'hFF);
    endtask

    // Random traffic under one mask setting
    task automatic test_random_traffic(logic [7:0] pm, logic [7:0] cm, int n);
        int          pick;
        int          sub;
        logic [15:0] addr;
        logic [3:0]  nib;
        wait_idle();
        cfg_write(bsmap_pkg::CFG_PRG_MASK, pm);
        cfg_write(bsmap_pkg::CFG_CHR_MASK, cm);
        mask_settings++;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                snk_idle_en = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                sub = $urandom_range(0, 9);
                case (sub)
                    0, 1, 2, 3: nib = 4'($urandom_range(0, 7));
                    4, 5:       nib = 4'($urandom_range(8, 11));
                    6:          nib = ($urandom_range(0, 15) == 0) ? 4'hD : 4'hF;
                    7:          nib = 4'hF;
                    default:    nib = ($urandom_range(0, 1) != 0) ? 4'hC : 4'hE;
                endcase
                addr = {3'b100, 9'($urandom), nib};
                if (sub == 9) begin
                    addr = 16'($urandom);
                end
                send_item(bsmap_pkg::FUNC_WRITE, addr, 8'($urandom));
            end else if (pick < 45) begin
                send_item(bsmap_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
            end else if (pick < 72) begin
                addr = 16'($urandom);
                addr[15] = ($urandom_range(0, 99) < 85);
                send_item(bsmap_pkg::FUNC_CPU_XLATE, addr, 8'($urandom));
            end else begin
                addr = 16'($urandom);
                if ($urandom_range(0, 99) < 85) begin
                    addr[15:13] = 3'b000;
                end
                send_item(bsmap_pkg::FUNC_CHR_XLATE, addr, 8'($urandom));
            end
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // Output side: stall for a random gap before each result when idling is enabled
    initial begin : result_sink
        int stall;
        forever begin
            stall = snk_idle_en ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_map_out exp_out;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (map_out_q.size() == 0) begin
                $error("result with no transaction pending");
                mismatches++;
            end else begin
                exp_out = map_out_q.pop_front();
                if (m_axis_tdata[0] !== exp_out.irq_line) begin
                    $error("irq_line: expected %0d, got %0d",
                           exp_out.irq_line, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[bsmap_pkg::MAP_ADDR_W:1] !== exp_out.mapped_address) begin
                    $error("mapped_address: expected 0x%06h, got 0x%06h",
                           exp_out.mapped_address, m_axis_tdata[bsmap_pkg::MAP_ADDR_W:1]);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== exp_out.mapped_valid) begin
                    $error("mapped_valid: expected %0d, got %0d",
                           exp_out.mapped_valid, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        apply_reset();
        test_reset_banks();
        test_bank_writes();
        test_zero_masks();
        test_cycle_irq();
        test_random_traffic(8'hFF, 8'hFF, RAND_PER_PHASE);
        test_random_traffic(8'h00, 8'h00, RAND_PER_PHASE);
        test_random_traffic(8'h0F, 8'hF0, RAND_PER_PHASE);
        test_random_traffic(8'($urandom), 8'($urandom), RAND_PER_PHASE);
        test_random_traffic(8'hFF, 8'h00, RAND_PER_PHASE);
        wait_idle();
        if (map_out_q.size() != 0) begin
            $error("%0d results never arrived", map_out_q.size());
            mismatches++;
        end
        $display("Sent %0d transactions (writes, ticks, CPU and pattern translates), %0d results",
                 items_sent, results_seen);
        $display("checked over %0d mask settings with counter clears; interrupt latched %0d times",
                 mask_settings, irq_rises);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
src/bsmap_pkg.sv
src/bank_switch_mapper_with_cycle_irq.sv
tb/bank_switch_mapper_with_cycle_irq_tb.sv
